// ===== hw/rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srt_pkg
// Shared widths, codes and controller/datapath link types for the sorted
// record table.
// ---------------------------------------------------------------------------
package srt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 31;
  localparam int SCORE_W = 16;
  localparam int POS_W   = 6;
  localparam int STS_W   = 2;
  localparam int ECNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_RD,
    S_HOLD
  } state_t;

  // result sources that the controller selects directly
  typedef enum logic [2:0] {
    RES_FULL,
    RES_NOT_FOUND,
    RES_BAD_POS,
    RES_NOP,
    RES_RD
  } res_sel_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    logic     ld;
    logic     go_ins;
    logic     go_del;
    logic     scan;
    logic     rd_issue;
    logic     set_res;
    res_sel_t res_sel;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_ok;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/srt_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srt_req_if
// Request channel of the sorted record table: valid/ready plus command.
// ---------------------------------------------------------------------------
interface srt_req_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key;
  logic [SCORE_W-1:0] score;
  logic [POS_W-1:0]   position;

  modport source (output valid, output cmd, output key, output score, output position,
                  input ready);
  modport sink (input valid, input cmd, input key, input score, input position,
                output ready);
endinterface

// ===== hw/rtl/srt_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srt_rsp_if
// Result channel of the sorted record table: valid/ready plus result.
// ---------------------------------------------------------------------------
interface srt_rsp_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STS_W-1:0]   status;
  logic [ECNT_W-1:0]  entry_count;
  logic [KEY_W-1:0]   key_out;
  logic [SCORE_W-1:0] score_out;

  modport source (output valid, output status, output entry_count, output key_out,
                  output score_out, input ready);
  modport sink (input valid, input status, input entry_count, input key_out,
                input score_out, output ready);
endinterface

// ===== hw/rtl/srt_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srt_ctrl
// Command sequencer: takes a request, dispatches it to the datapath,
// waits for the scan or the read and hands the result to the output register.
// ---------------------------------------------------------------------------
module srt_ctrl
  import srt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (stat.op)
          OP_INSERT: state_nxt = stat.full ? S_HOLD : S_SCAN;
          OP_DELETE: state_nxt = stat.empty ? S_HOLD : S_SCAN;
          OP_READ:   state_nxt = stat.pos_ok ? S_RD : S_HOLD;
          default:   state_nxt = S_HOLD;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_HOLD;
      end
      S_RD: state_nxt = S_HOLD;
      S_HOLD: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = RES_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.ld   = in_valid;
      end
      S_DISP: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.go_ins = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat.empty) begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_NOT_FOUND;
            end else begin
              cmd.go_del = 1'b1;
            end
          end
          OP_READ: begin
            if (stat.pos_ok) begin
              cmd.rd_issue = 1'b1;
            end else begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_BAD_POS;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_NOP;
          end
        endcase
      end
      S_SCAN: cmd.scan = 1'b1;
      S_RD: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_RD;
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/srt_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srt_dp
// Record memory, scan pointers and result registers. Insert walks the
// table backwards moving records up one slot; delete walks forwards
// moving records down once the key has been hit. One entry per cycle.
// ---------------------------------------------------------------------------
module srt_dp
  import srt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [POS_W-1:0]   in_position,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [STS_W-1:0]   out_status,
  output logic [ECNT_W-1:0]  out_entry_count,
  output logic [KEY_W-1:0]   out_key_out,
  output logic [SCORE_W-1:0] out_score_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  rec_t mem [CAPACITY];
  rec_t rdata_r;

  // request registers
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [SCORE_W-1:0] score_r;
  logic [POS_W-1:0]   pos_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] iptr_r, iptr_nxt;
  logic          idone_r, idone_nxt;
  logic          dval_r, dval_nxt;
  logic          dsent_r, dsent_nxt;
  logic [AW-1:0] dslot_r, dslot_nxt;
  logic          found_r, found_nxt;

  status_t            res_status_r, res_status_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic [SCORE_W-1:0] res_score_r, res_score_nxt;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  rec_t          wdata;
  logic          del_hit, del_last;
  logic          scan_done;

  assign stat.op        = op_r;
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.empty     = (count_r == '0);
  assign stat.pos_ok    = (int'(pos_r) < int'(count_r));
  assign stat.scan_done = scan_done;

  assign del_hit  = (rdata_r.key == key_r);
  assign del_last = ((CW'(dslot_r) + CW'(1)) == count_r);

  always_comb begin
    count_nxt      = count_r;
    iptr_nxt       = iptr_r;
    idone_nxt      = idone_r;
    dval_nxt       = 1'b0;
    dsent_nxt      = 1'b0;
    dslot_nxt      = dslot_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_score_nxt  = res_score_r;
    re             = 1'b0;
    we             = 1'b0;
    raddr          = iptr_r;
    waddr          = dslot_r;
    wdata          = rdata_r;
    scan_done      = 1'b0;

    if (cmd.go_ins) begin
      iptr_nxt  = AW'(count_r);
      idone_nxt = 1'b0;
    end
    if (cmd.go_del) begin
      iptr_nxt  = '0;
      idone_nxt = 1'b0;
      found_nxt = 1'b0;
    end
    if (cmd.rd_issue) begin
      re    = 1'b1;
      raddr = AW'(pos_r);
    end

    if (cmd.scan) begin
      // issue side: one read per cycle
      if (!idone_r) begin
        dval_nxt  = 1'b1;
        dslot_nxt = iptr_r;
        if (op_r == OP_INSERT) begin
          if (iptr_r != '0) begin
            re       = 1'b1;
            raddr    = iptr_r - AW'(1);
            iptr_nxt = iptr_r - AW'(1);
          end else begin
            // below slot 0 nothing to read: new record goes in slot 0
            dsent_nxt = 1'b1;
            idone_nxt = 1'b1;
          end
        end else begin
          re    = 1'b1;
          raddr = iptr_r;
          if ((CW'(iptr_r) + CW'(1)) == count_r) idone_nxt = 1'b1;
          else iptr_nxt = iptr_r + AW'(1);
        end
      end

      // return side: data of slot dslot_r (insert: from slot below)
      if (dval_r) begin
        if (op_r == OP_INSERT) begin
          we    = 1'b1;
          waddr = dslot_r;
          if (dsent_r || rdata_r.key <= key_r) begin
            wdata          = '{key: key_r, score: score_r};
            count_nxt      = count_r + CW'(1);
            res_status_nxt = STS_OK;
            res_key_nxt    = key_r;
            res_score_nxt  = '0;
            scan_done      = 1'b1;
          end
        end else begin
          if (found_r) begin
            we    = 1'b1;
            waddr = dslot_r - AW'(1);
          end else if (del_hit) begin
            found_nxt = 1'b1;
          end
          if (del_last) begin
            scan_done     = 1'b1;
            res_key_nxt   = key_r;
            res_score_nxt = '0;
            if (found_r || del_hit) begin
              count_nxt      = count_r - CW'(1);
              res_status_nxt = STS_OK;
            end else begin
              res_status_nxt = STS_NOT_FOUND;
            end
          end
        end
      end
    end

    if (cmd.set_res) begin
      case (cmd.res_sel)
        RES_FULL: begin
          res_status_nxt = STS_FULL;
          res_key_nxt    = key_r;
          res_score_nxt  = '0;
        end
        RES_NOT_FOUND: begin
          res_status_nxt = STS_NOT_FOUND;
          res_key_nxt    = key_r;
          res_score_nxt  = '0;
        end
        RES_BAD_POS: begin
          res_status_nxt = STS_BAD_POS;
          res_key_nxt    = '0;
          res_score_nxt  = '0;
        end
        RES_RD: begin
          res_status_nxt = STS_OK;
          res_key_nxt    = rdata_r.key;
          res_score_nxt  = rdata_r.score;
        end
        default: begin
          res_status_nxt = STS_OK;
          res_key_nxt    = '0;
          res_score_nxt  = '0;
        end
      endcase
    end
  end

  // record memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idone_r <= 1'b1;
      dval_r  <= 1'b0;
      dsent_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idone_r <= idone_nxt;
      dval_r  <= dval_nxt;
      dsent_r <= dsent_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iptr_r       <= iptr_nxt;
    dslot_r      <= dslot_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_score_r  <= res_score_nxt;
    if (cmd.ld) begin
      op_r    <= op_t'(in_cmd);
      key_r   <= in_key;
      score_r <= in_score;
      pos_r   <= in_position;
    end
    if (cmd.publish) begin
      out_status      <= res_status_r;
      out_entry_count <= ECNT_W'(count_r);
      out_key_out     <= res_key_r;
      out_score_out   <= res_score_r;
    end
  end

endmodule

// ===== hw/rtl/sorted_record_table_top.sv =====
`timescale 1ns / 1ps
// flow: request loaded, then dispatched; a read goes through S_RD, insert and delete walk the
//   table in S_SCAN; full insert, empty delete, bad position and unused code skip both
// throughput: one request at a time, the next accepted once the result is in the output
//   registers; the record memory walks one entry per cycle
// reset: entry count cleared, record memory left undefined (no clearing pass)
// ---------------------------------------------------------------------------
// sorted_record_table_top
// Bounded table of (key, score) records kept in ascending key order.
// ---------------------------------------------------------------------------
module sorted_record_table_top
  import srt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  srt_req_if.sink  in_req,
  srt_rsp_if.source out_rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_req.cmd),
    .in_key          (in_req.key),
    .in_score        (in_req.score),
    .in_position     (in_req.position),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_rsp.status),
    .out_entry_count (out_rsp.entry_count),
    .out_key_out     (out_rsp.key_out),
    .out_score_out   (out_rsp.score_out)
  );

  // an accepted request keeps the input closed until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while busy");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld, cmd.go_ins, cmd.go_del, cmd.scan, cmd.rd_issue, cmd.set_res,
              cmd.publish}))
    else $error("overlapping datapath commands");

  // publishing a result always raises the output valid
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_rsp.valid)
    else $error("published result not presented");

  // a scan finishes only while scanning
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_done |-> cmd.scan)
    else $error("scan completion outside scan");

endmodule

// ===== tb/sv/tb_sorted_record_table_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_record_table_top
// Drives insert, delete, read and unused-code requests into the sorted record
// table and keeps a mirror of the ordered table to predict every result.
// Results are compared field by field in arrival order, under random idle
// bursts on both channels.
// ---------------------------------------------------------------------------
module tb_sorted_record_table_top;
  import srt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [ECNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]   key_out;
    logic [SCORE_W-1:0] score_out;
  } table_result_t;

  class ordered_table_mirror;
    bit [KEY_W-1:0]   keys   [CAPACITY_DEF];
    bit [SCORE_W-1:0] scores [CAPACITY_DEF];
    int               held;
    table_result_t    awaited[$];
    int unsigned      mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    // update the mirror for one accepted request and queue its result
    function void note_request(op_t op, bit [KEY_W-1:0] k, bit [SCORE_W-1:0] s,
                               bit [POS_W-1:0] p);
      table_result_t r;
      int at;
      r = '{status: STS_OK, entry_count: '0, key_out: '0, score_out: '0};
      case (op)
        OP_INSERT: begin
          r.key_out = k;
          if (held >= CAPACITY_DEF) begin
            r.status = STS_FULL;
          end else begin
            // first stored key strictly larger, else append
            at = held;
            for (int i = held - 1; i >= 0; i--) if (keys[i] > k) at = i;
            for (int i = held; i > at; i--) begin
              keys[i]   = keys[i-1];
              scores[i] = scores[i-1];
            end
            keys[at]   = k;
            scores[at] = s;
            held++;
          end
        end
        OP_DELETE: begin
          r.key_out = k;
          at = -1;
          for (int i = held - 1; i >= 0; i--) if (keys[i] == k) at = i;
          if (at < 0) begin
            r.status = STS_NOT_FOUND;
          end else begin
            for (int i = at; i + 1 < held; i++) begin
              keys[i]   = keys[i+1];
              scores[i] = scores[i+1];
            end
            held--;
          end
        end
        OP_READ: begin
          if (p < held) begin
            r.key_out   = keys[p];
            r.score_out = scores[p];
          end else begin
            r.status = STS_BAD_POS;
          end
        end
        default: begin
        end
      endcase
      r.entry_count = ECNT_W'(held);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STS_W-1:0] st, logic [ECNT_W-1:0] cnt,
                               logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
      table_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d key_out %0h", st, cnt, k);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (cnt !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, cnt);
        mismatches++;
      end
      if (k !== want.key_out) begin
        $error("key_out: expected %0h, actual %0h", want.key_out, k);
        mismatches++;
      end
      if (s !== want.score_out) begin
        $error("score_out: expected %0h, actual %0h", want.score_out, s);
        mismatches++;
      end
    endfunction

    function bit [KEY_W-1:0] some_held_key();
      if (held == 0) return KEY_W'($urandom);
      return keys[$urandom_range(0, held - 1)];
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   bursts_on;
  int   issued;
  int   stall_left;

  ordered_table_mirror table_mirror = new();

  srt_req_if req_if ();
  srt_rsp_if rsp_if ();

  sorted_record_table_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall bursts, ready otherwise
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (bursts_on && $urandom_range(0, 19) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      rsp_if.ready = (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      table_mirror.check_result(rsp_if.status, rsp_if.entry_count, rsp_if.key_out,
                                rsp_if.score_out);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(op_t op, bit [KEY_W-1:0] k, bit [SCORE_W-1:0] s, bit [POS_W-1:0] p);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_if.valid    = 1'b1;
    req_if.cmd      = op;
    req_if.key      = k;
    req_if.score    = s;
    req_if.position = p;
    do @(posedge clk); while (!req_if.ready);
    table_mirror.note_request(op, k, s, p);
    issued++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (table_mirror.awaited.size() > 0) @(negedge clk);
  endtask

  // small key pool most of the time so deletes hit and equal keys pile up
  function automatic bit [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_W'($urandom);
      1:       return $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
      default: return KEY_W'($urandom_range(0, 47));
    endcase
  endfunction

  task automatic run_mix(int n, int ins_pct, int del_pct);
    int r;
    bit [KEY_W-1:0] k;
    bit [POS_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        issue(OP_INSERT, pick_key(), SCORE_W'($urandom), POS_W'($urandom));
      end else if (r < ins_pct + del_pct) begin
        k = ($urandom_range(0, 3) != 0) ? table_mirror.some_held_key() : pick_key();
        issue(OP_DELETE, k, SCORE_W'($urandom), POS_W'($urandom));
      end else if (r < 97) begin
        if (table_mirror.held > 0 && $urandom_range(0, 9) < 7)
          p = POS_W'($urandom_range(0, table_mirror.held - 1));
        else
          p = POS_W'($urandom);
        issue(OP_READ, KEY_W'($urandom), SCORE_W'($urandom), p);
      end else begin
        issue(OP_NOP, KEY_W'($urandom), SCORE_W'($urandom), POS_W'($urandom));
      end
    end
  endtask

  initial begin
    int mode;
    int seg;
    clk             = 1'b0;
    rst_n           = 1'b0;
    bursts_on       = 1'b1;
    issued          = 0;
    req_if.valid    = 1'b0;
    req_if.cmd      = OP_NOP;
    req_if.key      = '0;
    req_if.score    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // empty table corner cases
    issue(OP_READ, '0, '0, '0);
    issue(OP_DELETE, 31'd5, '0, '0);
    issue(OP_NOP, {KEY_W{1'b1}}, {SCORE_W{1'b1}}, {POS_W{1'b1}});
    // extremes, equal keys land after existing ones
    issue(OP_INSERT, {KEY_W{1'b1}}, {SCORE_W{1'b1}}, '0);
    issue(OP_INSERT, '0, '0, '0);
    issue(OP_INSERT, '0, 16'h1234, '0);
    issue(OP_INSERT, 31'd100, 16'h0180, '0);
    issue(OP_INSERT, 31'd100, 16'h0280, '0);
    issue(OP_INSERT, 31'h4000_0000, 16'h8000, '0);
    for (int i = 0; i < 6; i++) issue(OP_READ, '0, '0, POS_W'(i));
    issue(OP_READ, '0, '0, 6'd6);
    issue(OP_READ, '0, '0, {POS_W{1'b1}});
    issue(OP_DELETE, 31'd100, '0, '0);
    issue(OP_READ, '0, '0, 6'd2);
    issue(OP_DELETE, 31'd77, '0, '0);
    issue(OP_DELETE, {KEY_W{1'b1}}, '0, '0);
    issue(OP_DELETE, '0, '0, '0);
    issue(OP_READ, '0, '0, '0);
    issue(OP_NOP, '0, '0, '0);
    wait_drained();

    // fill past capacity so full refusals occur
    run_mix(72, 100, 0);
    seg = 0;
    while (issued < 650) begin
      if (issued >= 530) bursts_on = 1'b0;
      if (seg == 3) begin
        // a run of deletes, mostly of held keys, towards an empty table
        run_mix(72, 0, 100);
      end else begin
        mode = $urandom_range(0, 2);
        case (mode)
          0:       run_mix($urandom_range(30, 70), 70, 15);
          1:       run_mix($urandom_range(30, 70), 15, 65);
          default: run_mix($urandom_range(30, 70), 35, 35);
        endcase
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      seg++;
    end

    bursts_on = 1'b0;
    wait_drained();
    repeat (CAPACITY_DEF + 16) @(negedge clk);
    if (table_mirror.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/srt_pkg.sv
hw/rtl/srt_req_if.sv
hw/rtl/srt_rsp_if.sv
hw/rtl/srt_ctrl.sv
hw/rtl/srt_dp.sv
hw/rtl/sorted_record_table_top.sv
tb/sv/tb_sorted_record_table_top.sv
